// ----- rtl/tksl_pkg.sv -----
// Shared types and constants of the top-k score list.
`timescale 1ns / 1ps
package tksl_pkg;

  localparam int MAX_HITS = 16;
  localparam int IDX_W    = $clog2(MAX_HITS);
  localparam int CNT_W    = $clog2(MAX_HITS + 1);
  localparam int SCORE_W  = 16;
  localparam int ID_W     = 16;
  localparam int OP_W     = 2;
  localparam int RIDX_W   = 4;
  localparam int POS_W    = 4;
  localparam int FILL_W   = 5;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic                      go;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
    logic [CNT_W-1:0]          count;
    logic [CNT_W-1:0]          pos;
    logic [CNT_W-1:0]          last;
  } cell_bcast_t;

endpackage

// ----- rtl/tksl_if.sv -----
// Valid/ready channel interfaces for items into and results out of the list.
`timescale 1ns / 1ps
interface tksl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] hit_score;
  logic [15:0]        hit_id;
  logic [3:0]         read_index;

  modport source (output valid, op, hit_score, hit_id, read_index, input ready);
  modport sink   (input valid, op, hit_score, hit_id, read_index, output ready);
endinterface

interface tksl_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [3:0]         position;
  logic               evicted;
  logic [15:0]        evicted_id;
  logic               entry_valid;
  logic signed [15:0] entry_score;
  logic [15:0]        entry_id;
  logic [4:0]         fill_count;

  modport source (output valid, accepted, position, evicted, evicted_id, entry_valid,
                  entry_score, entry_id, fill_count, input ready);
  modport sink   (input valid, accepted, position, evicted, evicted_id, entry_valid,
                  entry_score, entry_id, fill_count, output ready);
endinterface

// ----- rtl/top_k_score_list.sv -----
// Top level of the top-k score list: cell chain, fill count and result register.
`timescale 1ns / 1ps
// Keeps up to keep_limit hits in falling score order in a row of 16 cells.
// Input channel in_i carries one item: op (insert, read, clear, no-op),
// hit_score, hit_id and read_index. Output channel out_o returns one result
// per item: insert outcome (accepted, position, evicted, evicted_id), read
// data (entry_valid, entry_score, entry_id) and fill_count after the item.
// Every cell compares its entry with the new score in parallel and shifts
// from its left neighbor on the same edge, so the result of an item appears
// in the output register in the cycle after the item is taken.
// Throughput is one item per cycle; the output register is the only stage.
// While a result waits on a stalled receiver, in_i.ready falls; an item is
// taken again in the cycle the waiting result leaves.
// Reset empties the list (fill count zero) and sets keep_limit to 16.
// keep_limit is written through cfg_we_i/cfg_data_i; the user must write it
// only while the block is idle, which the block does not enforce. 0 acts as 1,
// above 16 as 16. A limit under the fill level trims nothing; the list is full.
module top_k_score_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tksl_in_if.sink                       in_i,
  tksl_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [tksl_pkg::LIMIT_W-1:0]  cfg_data_i
);
  import tksl_pkg::*;

  logic [LIMIT_W-1:0]        keep_limit_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          lim_eff;
  logic                      full;
  logic                      take;
  op_e                       op;

  logic signed [SCORE_W-1:0] cell_score [MAX_HITS];
  logic [ID_W-1:0]           cell_id    [MAX_HITS];
  logic [MAX_HITS-1:0]       cell_lt;
  logic [MAX_HITS-1:0]       cell_first;
  cell_bcast_t               bcast;

  logic [CNT_W-1:0]          pos_enc, pos;
  logic                      any_lt, ins_go;
  logic [IDX_W-1:0]          ridx;
  logic                      rd_hit;
  logic signed [SCORE_W-1:0] rd_score;
  logic [ID_W-1:0]           rd_id, ev_id;
  logic [CNT_W-1:0]          last_idx;

  logic                      res_valid_q;
  logic                      accepted_q, evicted_q, entry_valid_q;
  logic [POS_W-1:0]          position_q;
  logic [ID_W-1:0]           evicted_id_q, entry_id_q;
  logic signed [SCORE_W-1:0] entry_score_q;
  logic [FILL_W-1:0]         fill_count_q;

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.op);

  // Clamp the configured limit into 1..MAX_HITS
  always_comb begin
    if (keep_limit_q == '0) begin
      lim_eff = CNT_W'(1);
    end else if (32'(keep_limit_q) > MAX_HITS) begin
      lim_eff = CNT_W'(MAX_HITS);
    end else begin
      lim_eff = CNT_W'(keep_limit_q);
    end
  end
  assign full = count_q >= lim_eff;

  // Encode the insert position from the one-hot first-beaten mark
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < MAX_HITS; i++) begin
      pos_enc = pos_enc | (cell_first[i] ? CNT_W'(i) : '0);
    end
  end
  assign any_lt   = |cell_lt;
  assign pos      = any_lt ? pos_enc : count_q;
  assign ins_go   = take && (op == OP_INSERT) && (!full || any_lt);
  assign last_idx = full ? (count_q - CNT_W'(1)) : count_q;

  assign bcast.go    = ins_go;
  assign bcast.score = in_i.hit_score;
  assign bcast.id    = in_i.hit_id;
  assign bcast.count = count_q;
  assign bcast.pos   = pos;
  assign bcast.last  = last_idx;

  // Chain of cells, each fed by its left neighbor
  for (genvar g = 0; g < MAX_HITS; g++) begin : g_cell
    if (g == 0) begin : g_head
      tksl_cell u_cell (
        .clk_i        (clk_i),
        .idx_i        (IDX_W'(g)),
        .bcast_i      (bcast),
        .left_score_i (in_i.hit_score),
        .left_id_i    (in_i.hit_id),
        .left_lt_i    (1'b0),
        .score_o      (cell_score[g]),
        .id_o         (cell_id[g]),
        .lt_o         (cell_lt[g]),
        .first_o      (cell_first[g])
      );
    end else begin : g_body
      tksl_cell u_cell (
        .clk_i        (clk_i),
        .idx_i        (IDX_W'(g)),
        .bcast_i      (bcast),
        .left_score_i (cell_score[g-1]),
        .left_id_i    (cell_id[g-1]),
        .left_lt_i    (cell_lt[g-1]),
        .score_o      (cell_score[g]),
        .id_o         (cell_id[g]),
        .lt_o         (cell_lt[g]),
        .first_o      (cell_first[g])
      );
    end
  end

  // Select the read entry and the worst entry by and-or over the cells
  assign ridx   = IDX_W'(in_i.read_index);
  assign rd_hit = CNT_W'(in_i.read_index) < count_q;
  always_comb begin
    rd_score = '0;
    rd_id    = '0;
    ev_id    = '0;
    for (int i = 0; i < MAX_HITS; i++) begin
      if (ridx == IDX_W'(i)) begin
        rd_score = rd_score | cell_score[i];
        rd_id    = rd_id | cell_id[i];
      end
      if (count_q - CNT_W'(1) == CNT_W'(i)) begin
        ev_id = ev_id | cell_id[i];
      end
    end
  end

  // Next fill count
  always_comb begin
    count_d = count_q;
    if (take) begin
      unique case (op)
        OP_INSERT: if (ins_go && !full) count_d = count_q + CNT_W'(1);
        OP_CLEAR:  count_d = '0;
        OP_READ,
        OP_NOP:    count_d = count_q;
        default:   count_d = count_q;
      endcase
    end
  end

  // Hold control state: limit, fill count, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_limit_q <= LIMIT_RESET;
      count_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) keep_limit_q <= cfg_data_i;
      count_q <= count_d;
      if (take) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result of each item
  always_ff @(posedge clk_i) begin
    if (take) begin
      accepted_q    <= ins_go;
      position_q    <= ins_go ? POS_W'(pos) : '0;
      evicted_q     <= ins_go && full;
      evicted_id_q  <= (ins_go && full) ? ev_id : '0;
      entry_valid_q <= (op == OP_READ) && rd_hit;
      entry_score_q <= ((op == OP_READ) && rd_hit) ? rd_score : '0;
      entry_id_q    <= ((op == OP_READ) && rd_hit) ? rd_id : '0;
      fill_count_q  <= FILL_W'(count_d);
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.accepted    = accepted_q;
  assign out_o.position    = position_q;
  assign out_o.evicted     = evicted_q;
  assign out_o.evicted_id  = evicted_id_q;
  assign out_o.entry_valid = entry_valid_q;
  assign out_o.entry_score = entry_score_q;
  assign out_o.entry_id    = entry_id_q;
  assign out_o.fill_count  = fill_count_q;

endmodule

// ----- rtl/tksl_cell.sv -----
// One list slot: holds a score and handle, compares and shifts from its left neighbor.
`timescale 1ns / 1ps
module tksl_cell (
  input  logic                               clk_i,
  input  logic [tksl_pkg::IDX_W-1:0]         idx_i,
  input  tksl_pkg::cell_bcast_t              bcast_i,
  input  logic signed [tksl_pkg::SCORE_W-1:0] left_score_i,
  input  logic [tksl_pkg::ID_W-1:0]          left_id_i,
  input  logic                               left_lt_i,
  output logic signed [tksl_pkg::SCORE_W-1:0] score_o,
  output logic [tksl_pkg::ID_W-1:0]          id_o,
  output logic                               lt_o,
  output logic                               first_o
);
  import tksl_pkg::*;

  logic signed [SCORE_W-1:0] score_q, score_d;
  logic [ID_W-1:0]           id_q, id_d;
  logic [CNT_W-1:0]          idx_ext;
  logic                      take_new, take_left;

  assign idx_ext = CNT_W'(idx_i);

  // Held entry is beaten by the new score; false past the fill level
  assign lt_o    = (idx_ext < bcast_i.count) && (score_q < bcast_i.score);
  // Leftmost beaten entry marks the insert position
  assign first_o = lt_o && !left_lt_i;

  assign take_new  = bcast_i.go && (idx_ext == bcast_i.pos);
  assign take_left = bcast_i.go && (idx_ext > bcast_i.pos) && (idx_ext <= bcast_i.last);

  // Load the new hit, shift the left neighbor in, or hold
  always_comb begin
    score_d = score_q;
    id_d    = id_q;
    if (take_new) begin
      score_d = bcast_i.score;
      id_d    = bcast_i.id;
    end else if (take_left) begin
      score_d = left_score_i;
      id_d    = left_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    id_q    <= id_d;
  end

  assign score_o = score_q;
  assign id_o    = id_q;

endmodule
